// File: design/rsc_pkg.sv
// Shared types, codes and sizes for the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_STEP_W  = $clog2(DATA_W);

    // command queue between front and back; depth must be a power of two
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_APPLY  = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_COPY = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] operand_value;
        logic [2:0]               op;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_APPLY,
        CMD_REDUCE,
        CMD_NOP
    } t_cmd_class;

    typedef struct packed {
        t_cmd_class        cls;
        logic [2:0]        op;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        XS_IDLE,
        XS_READ,
        XS_CALC,
        XS_DIVW,
        XS_COPY,
        XS_TOP_RD,
        XS_TOP_LD
    } t_xstate;

endpackage

`default_nettype wire

// File: design/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: front end, back end and their wiring.
`timescale 1ns / 1ps
`default_nettype none

// Integer RPN stack machine with a 64-entry stack of signed 32-bit values. Each item
// pushes a value, applies one operator to the top two entries, or folds the whole
// stack with one operator, and yields exactly one result: status, new top (zero when
// empty) and depth. Errors refuse the item and leave the stack as it was. A two-item
// command queue decouples the input from the execution unit. The back end takes its
// next command only once the result register is free or being popped, so while a
// result waits at most two more items are accepted before full rises. Divide uses the
// shared divider, one quotient bit per cycle, unless the divisor is zero; a copy that
// pushes nothing refetches the new top unless it leaves the stack empty; a fold steps
// down one entry at a time, a zero divisor ending it at the step that meets it. The
// stack RAM has one write port and one registered read port; reading one entry per
// step sets the pace of the fold, and copy writes one entry per cycle.
module rpn_stack_calculator import rsc_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_item,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_result
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    rsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_take      (cmd_take)
    );

    rsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// File: design/rsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/rsc_front.sv
// Front end: takes items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rsc_front import rsc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_item,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_take
);

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CMDQ_CNT_W-1:0] r_cnt, n_cnt;
    t_cmd                  v_cmd;
    logic                  push_ok;

    assign full        = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push_ok     = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // ops that mean nothing for their kind become no-ops here
    always_comb begin
        v_cmd.op    = i_item.op;
        v_cmd.value = i_item.operand_value;
        case (i_item.kind)
            KIND_PUSH:   v_cmd.cls = CMD_PUSH;
            KIND_APPLY:  v_cmd.cls = (i_item.op <= OP_COPY) ? CMD_APPLY : CMD_NOP;
            KIND_REDUCE: v_cmd.cls = (i_item.op < OP_COPY) ? CMD_REDUCE : CMD_NOP;
            default:     v_cmd.cls = CMD_NOP;
        endcase
    end

    always_comb begin
        n_wp  = push_ok ? r_wp + CMDQ_PTR_W'(1) : r_wp;
        n_rp  = i_take ? r_rp + CMDQ_PTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (push_ok && !i_take) begin
            n_cnt = r_cnt + CMDQ_CNT_W'(1);
        end else if (!push_ok && i_take) begin
            n_cnt = r_cnt - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= v_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/rsc_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module rsc_div import rsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DATA_W-1:0] o_quot
);

    logic                  r_busy, n_busy, r_done, n_done, r_neg, n_neg;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic [DATA_W-1:0]     r_rem, n_rem, r_q, n_q, r_dvs, n_dvs;
    logic [DATA_W:0]       v_trial;

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + DATA_W'(1)) : r_q;

    assign v_trial = {r_rem, r_q[DATA_W-1]} - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_step = r_step;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            // magnitude of the most negative value still fits as unsigned
            n_q    = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
            n_dvs  = i_divisor[DATA_W-1] ? (~i_divisor + DATA_W'(1)) : i_divisor;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!v_trial[DATA_W]) begin
                n_rem = v_trial[DATA_W-1:0];
                n_q   = {r_q[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DATA_W-2:0], r_q[DATA_W-1]};
                n_q   = {r_q[DATA_W-2:0], 1'b0};
            end
            n_step = r_step + DIV_STEP_W'(1);
            if (r_step == DIV_STEP_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_dvs  <= n_dvs;
    end

endmodule

`default_nettype wire

// File: design/rsc_back.sv
// Back end: stack store, sequencer for push/apply/copy/reduce, result register.
`timescale 1ns / 1ps
`default_nettype none

module rsc_back import rsc_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cmd_valid,
    input  wire t_cmd      i_cmd,
    output logic           o_take,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_result
);

    t_xstate           r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_wa, n_wa, r_k, n_k;
    logic [DATA_W-1:0] r_top, n_top, r_acc, n_acc;
    logic [ADDR_W-1:0] r_ra, n_ra;
    logic [2:0]        r_op, n_op;
    logic              r_single, n_single;
    logic              r_res_valid, n_res_valid;
    t_out_item         r_res, n_res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_quot;

    logic              res_free, res_load;
    logic [CNT_W-1:0]  v_base, v_n;
    logic [CNT_W:0]    v_sum;
    logic              v_big, v_step;
    logic [DATA_W-1:0] v_res;

    function automatic t_out_item mk_res(input logic [1:0] st, input logic [CNT_W-1:0] cnt,
                                         input logic [DATA_W-1:0] top);
        t_out_item r;
        r.status    = st;
        r.top_value = (cnt == '0) ? '0 : top;
        r.depth     = DEPTH_W'(cnt);
        return r;
    endfunction

    rsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ram_rdata),
        .i_divisor  (r_acc),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign empty    = !r_res_valid;
    assign o_result = r_res;
    assign res_free = !r_res_valid || pop;

    // copy bookkeeping, from the cached top as count
    assign v_base = r_cnt - CNT_W'(2);
    assign v_big  = !r_top[DATA_W-1] && (|r_top[DATA_W-2:CNT_W]);
    assign v_n    = r_top[DATA_W-1] ? '0 : r_top[CNT_W-1:0];
    assign v_sum  = {1'b0, v_base} + {1'b0, v_n};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_top       = r_top;
        n_acc       = r_acc;
        n_ra        = r_ra;
        n_wa        = r_wa;
        n_k         = r_k;
        n_op        = r_op;
        n_single    = r_single;
        n_res       = r_res;
        res_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_ra;
        ram_wdata   = r_acc;
        ram_raddr   = r_ra;
        div_start   = 1'b0;
        o_take      = 1'b0;
        v_step      = 1'b0;
        v_res       = r_acc;

        case (r_state)
            XS_IDLE: begin
                if (i_cmd_valid && res_free) begin
                    o_take = 1'b1;
                    n_op   = i_cmd.op;
                    case (i_cmd.cls)
                        CMD_PUSH: begin
                            res_load = 1'b1;
                            if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                                n_res = mk_res(ST_OVER, r_cnt, r_top);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[ADDR_W-1:0];
                                ram_wdata = i_cmd.value;
                                n_cnt     = r_cnt + CNT_W'(1);
                                n_top     = i_cmd.value;
                                n_res     = mk_res(ST_OK, r_cnt + CNT_W'(1), i_cmd.value);
                            end
                        end
                        CMD_APPLY: begin
                            if (r_cnt < CNT_W'(2)) begin
                                res_load = 1'b1;
                                n_res    = mk_res(ST_UNDER, r_cnt, r_top);
                            end else if (i_cmd.op == OP_COPY) begin
                                if (v_big || v_sum > (CNT_W + 1)'(STACK_DEPTH)) begin
                                    res_load = 1'b1;
                                    n_res    = mk_res(ST_OVER, r_cnt, r_top);
                                end else if (v_n == '0) begin
                                    // both popped, nothing pushed: refetch the new top
                                    n_cnt = v_base;
                                    if (v_base == '0) begin
                                        res_load = 1'b1;
                                        n_res    = mk_res(ST_OK, v_base, r_top);
                                    end else begin
                                        n_ra    = ADDR_W'(v_base - CNT_W'(1));
                                        n_state = XS_TOP_RD;
                                    end
                                end else begin
                                    n_ra    = ADDR_W'(v_base);
                                    n_wa    = v_base;
                                    n_k     = v_n;
                                    n_state = XS_READ;
                                end
                            end else begin
                                n_acc    = r_top;
                                n_ra     = ADDR_W'(v_base);
                                n_single = 1'b1;
                                n_state  = XS_READ;
                            end
                        end
                        CMD_REDUCE: begin
                            if (r_cnt == '0) begin
                                res_load = 1'b1;
                                n_res    = mk_res(ST_UNDER, r_cnt, r_top);
                            end else if (r_cnt == CNT_W'(1)) begin
                                res_load = 1'b1;
                                n_res    = mk_res(ST_OK, r_cnt, r_top);
                            end else begin
                                n_acc    = r_top;
                                n_ra     = ADDR_W'(v_base);
                                n_single = 1'b0;
                                n_state  = XS_READ;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                            n_res    = mk_res(ST_OK, r_cnt, r_top);
                        end
                    endcase
                end
            end
            XS_READ: begin
                n_state = XS_CALC;
            end
            XS_CALC: begin
                // ram_rdata is the left operand, r_acc the right one
                case (r_op)
                    OP_ADD: begin
                        v_res  = ram_rdata + r_acc;
                        v_step = 1'b1;
                    end
                    OP_SUB: begin
                        v_res  = ram_rdata - r_acc;
                        v_step = 1'b1;
                    end
                    OP_MUL: begin
                        v_res  = ram_rdata * r_acc;
                        v_step = 1'b1;
                    end
                    OP_DIV: begin
                        if (r_acc == '0) begin
                            // refused as a whole: nothing was written yet
                            res_load = 1'b1;
                            n_res    = mk_res(ST_DIVZERO, r_cnt, r_top);
                            n_state  = XS_IDLE;
                        end else begin
                            div_start = 1'b1;
                            n_state   = XS_DIVW;
                        end
                    end
                    OP_COPY: begin
                        n_acc   = ram_rdata;
                        n_state = XS_COPY;
                    end
                    default: begin
                        res_load = 1'b1;
                        n_res    = mk_res(ST_OK, r_cnt, r_top);
                        n_state  = XS_IDLE;
                    end
                endcase
            end
            XS_DIVW: begin
                if (div_done) begin
                    v_res  = div_quot;
                    v_step = 1'b1;
                end
            end
            XS_COPY: begin
                ram_we    = 1'b1;
                ram_waddr = r_wa[ADDR_W-1:0];
                ram_wdata = r_acc;
                n_wa      = r_wa + CNT_W'(1);
                n_k       = r_k - CNT_W'(1);
                if (r_k == CNT_W'(1)) begin
                    n_cnt    = r_wa + CNT_W'(1);
                    n_top    = r_acc;
                    res_load = 1'b1;
                    n_res    = mk_res(ST_OK, r_wa + CNT_W'(1), r_acc);
                    n_state  = XS_IDLE;
                end
            end
            XS_TOP_RD: begin
                n_state = XS_TOP_LD;
            end
            XS_TOP_LD: begin
                n_top    = ram_rdata;
                res_load = 1'b1;
                n_res    = mk_res(ST_OK, r_cnt, ram_rdata);
                n_state  = XS_IDLE;
            end
            default: begin
                n_state = XS_IDLE;
            end
        endcase

        // one step done: finish a single apply or at the bottom entry, else fetch the next one
        if (v_step) begin
            if (r_single || r_ra == '0) begin
                ram_we    = 1'b1;
                ram_waddr = r_ra;
                ram_wdata = v_res;
                n_cnt     = CNT_W'(r_ra) + CNT_W'(1);
                n_top     = v_res;
                res_load  = 1'b1;
                n_res     = mk_res(ST_OK, CNT_W'(r_ra) + CNT_W'(1), v_res);
                n_state   = XS_IDLE;
            end else begin
                n_acc   = v_res;
                n_ra    = r_ra - ADDR_W'(1);
                n_state = XS_READ;
            end
        end

        n_res_valid = res_load || (r_res_valid && !pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= XS_IDLE;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_acc    <= n_acc;
        r_ra     <= n_ra;
        r_wa     <= n_wa;
        r_k      <= n_k;
        r_op     <= n_op;
        r_single <= n_single;
        r_res    <= n_res;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_res_valid || pop))
        else $error("result written over an unread one");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_acc != '0))
        else $error("divider started with zero divisor");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == XS_COPY) |-> (r_k != '0))
        else $error("copy loop with no entries left");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_state != XS_IDLE) || $past(res_load))
        else $error("command taken without result or work");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the RPN stack calculator: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import rsc_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;   // no such kind, block ignores it
    localparam logic [2:0] OP_SPARE_LO = 3'd5;   // op codes past copy are ignored
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         CYCLE_LIMIT = 10_000_000;
    localparam int         DRAIN_WAIT  = 100;
    localparam int         PHASE_ITEMS = 400;
    localparam int         HOLD_CYCLES = 400;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    // predicted calculator state
    logic [DATA_W-1:0] stk [STACK_DEPTH];
    int                stk_cnt = 0;

    t_out_item pending_res_q[$];
    t_dir_row  dir_q[$];
    int        fails = 0;
    int        cycles = 0;
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        pop_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;

    rpn_stack_calculator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic bit arith(input logic [2:0] op, input logic [DATA_W-1:0] lhs,
                                 input logic [DATA_W-1:0] rhs,
                                 output logic [DATA_W-1:0] res);
        longint num;
        longint den;
        res = '0;
        case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
                if (rhs == '0) return 1'b0;
                num = longint'($signed(lhs));
                den = longint'($signed(rhs));
                res = DATA_W'(num / den);    // most negative / -1 wraps back on itself
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [1:0] apply_op(input logic [2:0] op);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        longint            n;
        int                base;
        if (op > OP_COPY) return ST_OK;
        if (stk_cnt < 2) return ST_UNDER;
        rhs = stk[stk_cnt-1];
        lhs = stk[stk_cnt-2];
        if (op == OP_COPY) begin
            n    = longint'($signed(rhs));
            base = stk_cnt - 2;
            if (n < 0) n = 0;
            if (base + n > STACK_DEPTH) return ST_OVER;
            for (int k = 0; k < n; k++) stk[base+k] = lhs;
            stk_cnt = base + int'(n);
            return ST_OK;
        end
        if (!arith(op, lhs, rhs, res)) return ST_DIVZERO;
        stk_cnt--;
        stk[stk_cnt-1] = res;
        return ST_OK;
    endfunction

    function automatic logic [1:0] reduce_stack(input logic [2:0] op);
        logic [DATA_W-1:0] acc;
        if (op >= OP_COPY) return ST_OK;
        if (stk_cnt == 0) return ST_UNDER;
        acc = stk[stk_cnt-1];
        for (int k = stk_cnt - 1; k > 0; k--) begin
            // a zero divisor anywhere refuses the whole item
            if (!arith(op, stk[k-1], acc, acc)) return ST_DIVZERO;
        end
        stk[0]  = acc;
        stk_cnt = 1;
        return ST_OK;
    endfunction

    function automatic t_out_item calc_step(input t_in_item it);
        t_out_item r;
        r.status = ST_OK;
        case (it.kind)
            KIND_PUSH: begin
                if (stk_cnt >= STACK_DEPTH) r.status = ST_OVER;
                else begin
                    stk[stk_cnt] = it.operand_value;
                    stk_cnt++;
                end
            end
            KIND_APPLY:  r.status = apply_op(it.op);
            KIND_REDUCE: r.status = reduce_stack(it.op);
            default: ;
        endcase
        r.top_value = (stk_cnt != 0) ? stk[stk_cnt-1] : '0;
        r.depth     = stk_cnt[DEPTH_W-1:0];
        return r;
    endfunction

    // ---------------- sender ----------------

    // Entered just after a falling edge; leaves just after the falling edge that
    // follows acceptance, with push still high.
    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push   = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = calc_step(it);
        pending_res_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 50) return int'($urandom_range(18)) - 9;
        return $urandom;
    endfunction

    task automatic send_simple(input logic [1:0] kind, input logic [DATA_W-1:0] value,
                               input logic [2:0] op);
        t_in_item it;
        it.kind          = kind;
        it.operand_value = value;
        it.op            = op;
        offer_item(it, 1'b0, '0);
        items_sent++;
    endtask

    // One well-formed step (or a short sequence), with occasional noise.
    task automatic random_burst();
        int       push_pct;
        int       roll;
        int       cnt;
        t_in_item it;
        push_pct = (stk_cnt < 2) ? 75 : ((stk_cnt > 24) ? 15 : 40);
        roll     = $urandom_range(99);
        if ($urandom_range(99) < 3) begin
            it.kind          = 2'($urandom_range(KIND_NONE));
            it.operand_value = $urandom;
            it.op            = 3'($urandom_range(OP_SPARE_HI));
            offer_item(it, 1'b0, '0);
            items_sent++;
        end else if (roll < push_pct) begin
            send_simple(KIND_PUSH, pick_value(), OP_ADD);
        end else if (roll < push_pct + 10) begin
            // copy: count pushed first; now and then aim at the stack limit
            if ($urandom_range(9) == 0)
                cnt = STACK_DEPTH - (stk_cnt - 1) + int'($urandom_range(2)) - 1;
            else
                cnt = int'($urandom_range(7)) - 2;
            send_simple(KIND_PUSH, cnt, OP_ADD);
            send_simple(KIND_APPLY, pick_value(), OP_COPY);
        end else if (roll < push_pct + 16) begin
            send_simple(KIND_REDUCE, pick_value(), 3'($urandom_range(OP_COPY)));
        end else begin
            send_simple(KIND_APPLY, pick_value(), 3'($urandom_range(OP_DIV)));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int stop_at;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        stop_at       = items_sent + n_items;
        while (items_sent < stop_at) random_burst();
    endtask

    function automatic void add_row(input logic [1:0] kind, input logic [DATA_W-1:0] value,
                                    input logic [2:0] op, input bit typed,
                                    input logic [1:0] st, input logic [DATA_W-1:0] top,
                                    input int dep);
        t_dir_row row;
        row.stim.kind          = kind;
        row.stim.operand_value = value;
        row.stim.op            = op;
        row.typed              = typed;
        row.want.status        = st;
        row.want.top_value     = top;
        row.want.depth         = dep[DEPTH_W-1:0];
        dir_q.push_back(row);
    endfunction

    // ---------------- receiver ----------------

    always begin : pop_drive
        @(negedge i_clk);
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            pop = ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_res_q.size() == 0) begin
                $error("result with no item pending: status %0d top %0d depth %0d",
                       o_result.status, o_result.top_value, o_result.depth);
                fails++;
            end else begin
                want = pending_res_q.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    fails++;
                end
                if (o_result.top_value !== want.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           want.top_value, o_result.top_value);
                    fails++;
                end
                if (o_result.depth !== want.depth) begin
                    $error("depth: expected %0d, got %0d", want.depth, o_result.depth);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        push    = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // rows with obvious outcomes carry their expected result
        add_row(KIND_REDUCE, 32'h0,         OP_ADD, 1, ST_UNDER,   32'h0,         0);
        add_row(KIND_PUSH,   32'h7fff_ffff, OP_ADD, 1, ST_OK,      32'h7fff_ffff, 1);
        add_row(KIND_APPLY,  32'h0,         OP_MUL, 1, ST_UNDER,   32'h7fff_ffff, 1);
        add_row(KIND_REDUCE, 32'h0,         OP_DIV, 1, ST_OK,      32'h7fff_ffff, 1);
        add_row(KIND_PUSH,   32'h1,         OP_ADD, 1, ST_OK,      32'h1,         2);
        add_row(KIND_APPLY,  32'h0,         OP_ADD, 1, ST_OK,      32'h8000_0000, 1);
        add_row(KIND_PUSH,   32'hffff_ffff, OP_ADD, 1, ST_OK,      32'hffff_ffff, 2);
        add_row(KIND_APPLY,  32'h0,         OP_DIV, 1, ST_OK,      32'h8000_0000, 1);
        add_row(KIND_PUSH,   32'h0,         OP_ADD, 1, ST_OK,      32'h0,         2);
        add_row(KIND_APPLY,  32'h0,         OP_DIV, 1, ST_DIVZERO, 32'h0,         2);
        add_row(KIND_APPLY,  32'h0,         OP_SUB, 1, ST_OK,      32'h8000_0000, 1);
        add_row(KIND_PUSH,   32'hffff_fff9, OP_ADD, 1, ST_OK,      32'hffff_fff9, 2);
        // copy positive count, copy negative count, then fill to the limit exactly
        add_row(KIND_PUSH,   32'd3,         OP_ADD,  0, ST_OK, 32'h0, 0);
        add_row(KIND_APPLY,  32'h0,         OP_COPY, 0, ST_OK, 32'h0, 0);
        add_row(KIND_PUSH,   32'hffff_fffb, OP_ADD,  0, ST_OK, 32'h0, 0);
        add_row(KIND_APPLY,  32'h0,         OP_COPY, 0, ST_OK, 32'h0, 0);
        add_row(KIND_PUSH,   32'd62,        OP_ADD,  0, ST_OK, 32'h0, 0);
        add_row(KIND_APPLY,  32'h0,         OP_COPY, 0, ST_OK, 32'h0, 0);
        add_row(KIND_PUSH,   32'h1,         OP_ADD,  0, ST_OK, 32'h0, 0);
        // ignored items, then a multiply fold of the full stack
        add_row(KIND_APPLY,  32'h0,         OP_SPARE_LO, 0, ST_OK, 32'h0, 0);
        add_row(KIND_NONE,   32'hffff_ffff, OP_SPARE_HI, 0, ST_OK, 32'h0, 0);
        add_row(KIND_REDUCE, 32'h0,         OP_COPY,     0, ST_OK, 32'h0, 0);
        add_row(KIND_REDUCE, 32'h0,         OP_MUL,      0, ST_OK, 32'h0, 0);
        // zero divisor met part way through the fold, then a clean fold
        add_row(KIND_PUSH,   32'h0,         OP_ADD, 0, ST_OK, 32'h0, 0);
        add_row(KIND_PUSH,   32'd5,         OP_ADD, 0, ST_OK, 32'h0, 0);
        add_row(KIND_REDUCE, 32'h0,         OP_DIV, 0, ST_OK, 32'h0, 0);
        add_row(KIND_REDUCE, 32'h0,         OP_SUB, 0, ST_OK, 32'h0, 0);

        @(negedge i_clk);
        foreach (dir_q[i]) offer_item(dir_q[i].stim, dir_q[i].typed, dir_q[i].want);

        run_phase(0,  0,  PHASE_ITEMS);
        run_phase(56, 0,  PHASE_ITEMS);
        run_phase(0,  56, PHASE_ITEMS);
        run_phase(28, 28, PHASE_ITEMS);

        // long hold on the result side while items keep coming: input must stall
        hold_req = 1'b1;
        run_phase(0, 0, 60);

        push = 1'b0;
        while (pending_res_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
